// ===== design/kpl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kpl_pkg;

    localparam int CURSOR_W = 3;
    localparam int CODE_W   = 48;

    localparam logic [1:0] PH_ENTRY   = 2'd0;
    localparam logic [1:0] PH_OLD     = 2'd1;
    localparam logic [1:0] PH_NEW     = 2'd2;
    localparam logic [1:0] PH_CONFIRM = 2'd3;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_ENTRY    = 3'd1;
    localparam logic [2:0] EV_OLD_BAD  = 3'd2;
    localparam logic [2:0] EV_OLD_OK   = 3'd3;
    localparam logic [2:0] EV_NEW      = 3'd4;
    localparam logic [2:0] EV_MISMATCH = 3'd5;
    localparam logic [2:0] EV_CHANGED  = 3'd6;

    localparam logic [7:0] KEY_ZERO  = 8'h30;
    localparam logic [7:0] KEY_NINE  = 8'h39;
    localparam logic [7:0] KEY_ERASE = 8'h2A;
    localparam logic [7:0] KEY_ONE   = 8'h31;
    localparam logic [7:0] CHR_SPACE = 8'h20;

    localparam logic OP_KEY    = 1'b0;
    localparam logic OP_CHANGE = 1'b1;

    typedef struct packed {
        logic [1:0]          phase;
        logic [CURSOR_W-1:0] cursor;
        logic                echo_valid;
        logic [2:0]          echo_column;
        logic [7:0]          echo_char;
        logic [2:0]          event_res;
        logic [CODE_W-1:0]   entry_code;
    } kpl_result_t;

endpackage

`default_nettype wire

// ===== design/kpl_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kpl_step #(
    parameter int CODE_DIGITS = 6
) (
    input  wire logic                            op,
    input  wire logic [7:0]                      key,
    input  wire logic [1:0]                      mode,
    input  wire logic [kpl_pkg::CURSOR_W-1:0]    count,
    input  wire logic [CODE_DIGITS-1:0][7:0]     stored,
    input  wire logic [CODE_DIGITS-1:0][7:0]     entry,
    input  wire logic [CODE_DIGITS-1:0][7:0]     new_code,
    output logic      [1:0]                      mode_next,
    output logic      [kpl_pkg::CURSOR_W-1:0]    count_next,
    output logic      [CODE_DIGITS-1:0][7:0]     stored_next,
    output logic      [CODE_DIGITS-1:0][7:0]     entry_next,
    output logic      [CODE_DIGITS-1:0][7:0]     new_code_next,
    output kpl_pkg::kpl_result_t                 result
);
    import kpl_pkg::*;

    localparam logic [CURSOR_W:0] FULL = (CURSOR_W + 1)'(CODE_DIGITS);

    logic [CURSOR_W:0]          inc;
    logic [CODE_DIGITS*8-1:0]   packed_code;

    assign inc = {1'b0, count} + 1'b1;

    always_comb begin
        mode_next     = mode;
        count_next    = count;
        stored_next   = stored;
        entry_next    = entry;
        new_code_next = new_code;
        packed_code   = '0;
        result        = '0;

        if (op == OP_CHANGE) begin
            if (mode == PH_ENTRY) begin
                mode_next  = PH_OLD;
                count_next = '0;
            end
        end else if (key inside {[KEY_ZERO:KEY_NINE]}) begin
            result.echo_valid  = 1'b1;
            result.echo_column = count;
            result.echo_char   = key;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                if (CURSOR_W'(i) == count) begin
                    entry_next[i] = key;
                end
            end
            if (inc == FULL) begin
                count_next        = '0;
                for (int i = 0; i < CODE_DIGITS; i++) begin
                    packed_code[(CODE_DIGITS-1-i)*8 +: 8] = entry_next[i];
                end
                result.entry_code = CODE_W'(64'(packed_code));
                case (mode)
                    PH_ENTRY: begin
                        result.event_res = EV_ENTRY;
                    end
                    PH_OLD: begin
                        if (entry_next == stored) begin
                            result.event_res = EV_OLD_OK;
                            mode_next        = PH_NEW;
                        end else begin
                            result.event_res = EV_OLD_BAD;
                        end
                    end
                    PH_NEW: begin
                        new_code_next    = entry_next;
                        result.event_res = EV_NEW;
                        mode_next        = PH_CONFIRM;
                    end
                    default: begin
                        if (entry_next == new_code) begin
                            stored_next      = new_code;
                            result.event_res = EV_CHANGED;
                            mode_next        = PH_ENTRY;
                        end else begin
                            result.event_res = EV_MISMATCH;
                            mode_next        = PH_NEW;
                        end
                    end
                endcase
            end else begin
                count_next = inc[CURSOR_W-1:0];
            end
        end else if (key == KEY_ERASE) begin
            if (count != '0) begin
                count_next         = count - 1'b1;
                result.echo_valid  = 1'b1;
                result.echo_column = count - 1'b1;
                result.echo_char   = CHR_SPACE;
            end
        end

        result.phase  = mode_next;
        result.cursor = count_next;
    end

endmodule

`default_nettype wire

// ===== design/keypad_password_lock_sequencer_top.sv =====
// Keypad code lock sequencer.
// Input channel (s_valid/s_ready): one item per key event; s_op = 0 is a key
// press with its ASCII code on s_key, s_op = 1 is a change-code request.
// Result channel (m_valid/m_ready): exactly one result item per input item,
// in order, carrying phase, cursor, display echo, event and completed code.
// An accepted item lands in the input register; its result from kpl_step is
// loaded into the result register once that is free or being read, and drives m_.
// Throughput: one item per cycle; the whole step (digit write, six-byte
// compare, phase update) is one combinational pass between the input and
// result registers, so nothing limits the rate but the receiver.
// Reset (aresetn low, synchronous): both stages empty, phase entry, cursor 0,
// stored code all '1', entry and new-code buffers zero.
// Receiver stall: the result register holds; one more item may wait in the
// input register, after which s_ready drops until m_ready returns.
`timescale 1ns / 1ps
`default_nettype none

module keypad_password_lock_sequencer_top #(
    parameter int CODE_DIGITS = 6
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_op,
    input  wire logic [7:0]                     s_key,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [1:0]                     m_phase,
    output logic      [kpl_pkg::CURSOR_W-1:0]   m_cursor,
    output logic                                m_echo_valid,
    output logic      [2:0]                     m_echo_column,
    output logic      [7:0]                     m_echo_char,
    output logic      [2:0]                     m_event_res,
    output logic      [kpl_pkg::CODE_W-1:0]     m_entry_code
);
    import kpl_pkg::*;

    logic                          in_valid_reg;
    logic                          in_op_reg;
    logic [7:0]                    in_key_reg;
    logic                          out_valid_reg;
    kpl_result_t                   out_reg;
    kpl_result_t                   result;

    logic [1:0]                    mode_reg, mode_next;
    logic [CURSOR_W-1:0]           count_reg, count_next;
    logic [CODE_DIGITS-1:0][7:0]   stored_reg, stored_next;
    logic [CODE_DIGITS-1:0][7:0]   entry_reg, entry_next;
    logic [CODE_DIGITS-1:0][7:0]   new_code_reg, new_code_next;

    logic                          advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    kpl_step #(
        .CODE_DIGITS(CODE_DIGITS)
    ) u_step (
        .op           (in_op_reg),
        .key          (in_key_reg),
        .mode         (mode_reg),
        .count        (count_reg),
        .stored       (stored_reg),
        .entry        (entry_reg),
        .new_code     (new_code_reg),
        .mode_next    (mode_next),
        .count_next   (count_next),
        .stored_next  (stored_next),
        .entry_next   (entry_next),
        .new_code_next(new_code_next),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= PH_ENTRY;
            count_reg     <= '0;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                stored_reg[i]   <= KEY_ONE;
                entry_reg[i]    <= '0;
                new_code_reg[i] <= '0;
            end
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                count_reg     <= count_next;
                stored_reg    <= stored_next;
                entry_reg     <= entry_next;
                new_code_reg  <= new_code_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg  <= s_op;
            in_key_reg <= s_key;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_phase       = out_reg.phase;
    assign m_cursor      = out_reg.cursor;
    assign m_echo_valid  = out_reg.echo_valid;
    assign m_echo_column = out_reg.echo_column;
    assign m_echo_char   = out_reg.echo_char;
    assign m_event_res   = out_reg.event_res;
    assign m_entry_code  = out_reg.entry_code;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import kpl_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_TARGET = 1535;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [7:0]  s_key;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_phase;
    logic [CURSOR_W-1:0] m_cursor;
    logic        m_echo_valid;
    logic [2:0]  m_echo_column;
    logic [7:0]  m_echo_char;
    logic [2:0]  m_event_res;
    logic [CODE_W-1:0] m_entry_code;

    keypad_password_lock_sequencer_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_phase       (m_phase),
        .m_cursor      (m_cursor),
        .m_echo_valid  (m_echo_valid),
        .m_echo_column (m_echo_column),
        .m_echo_char   (m_echo_char),
        .m_event_res   (m_event_res),
        .m_entry_code  (m_entry_code)
    );

    always #10 aclk = ~aclk;

    // Lock state as the block should hold it; first digit in the top byte.
    logic [47:0] stored_code;
    logic [47:0] entry_digits;
    logic [47:0] pending_code;
    logic [2:0]  digits_held;
    logic [1:0]  lock_phase;

    kpl_result_t expected_results[$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  effective_items = 0;
    int  results_seen = 0;
    int  event_tally[8];
    int  holds_done = 0;
    int  idle_cycles = 0;
    bit  no_gaps = 1'b0;
    int  rx_hold_cycles = 0;
    bit  rx_holding = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic kpl_result_t lock_predict(input logic op, input logic [7:0] key);
        kpl_result_t r;
        r = '0;
        if (op == OP_CHANGE) begin
            if (lock_phase == PH_ENTRY) begin
                lock_phase  = PH_OLD;
                digits_held = '0;
            end
        end else if (key >= KEY_ZERO && key <= KEY_NINE) begin
            if (digits_held < 3'd6) begin
                r.echo_valid  = 1'b1;
                r.echo_column = digits_held;
                r.echo_char   = key;
                entry_digits[47 - 8*int'(digits_held) -: 8] = key;
                digits_held = digits_held + 3'd1;
            end
            if (digits_held >= 3'd6) begin
                digits_held  = '0;
                r.entry_code = entry_digits;
                case (lock_phase)
                    PH_ENTRY: begin
                        r.event_res = EV_ENTRY;
                    end
                    PH_OLD: begin
                        if (entry_digits == stored_code) begin
                            r.event_res = EV_OLD_OK;
                            lock_phase  = PH_NEW;
                        end else begin
                            r.event_res = EV_OLD_BAD;
                        end
                    end
                    PH_NEW: begin
                        pending_code = entry_digits;
                        r.event_res  = EV_NEW;
                        lock_phase   = PH_CONFIRM;
                    end
                    PH_CONFIRM: begin
                        if (entry_digits == pending_code) begin
                            stored_code = pending_code;
                            r.event_res = EV_CHANGED;
                            lock_phase  = PH_ENTRY;
                        end else begin
                            r.event_res = EV_MISMATCH;
                            lock_phase  = PH_NEW;
                        end
                    end
                endcase
            end
        end else if (key == KEY_ERASE) begin
            if (digits_held > 3'd0) begin
                digits_held   = digits_held - 3'd1;
                r.echo_valid  = 1'b1;
                r.echo_column = digits_held;
                r.echo_char   = CHR_SPACE;
            end
        end
        r.phase  = lock_phase;
        r.cursor = digits_held;
        return r;
    endfunction

    task automatic send_item(input logic op, input logic [7:0] key);
        int gap;
        kpl_result_t exp;
        logic [1:0] prev_phase;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_key   <= key;
        do @(posedge aclk); while (!s_ready);
        prev_phase = lock_phase;
        exp = lock_predict(op, key);
        expected_results.push_back(exp);
        items_sent++;
        if (exp.echo_valid || exp.event_res != EV_NONE || exp.phase != prev_phase)
            effective_items++;
    endtask

    task automatic sender_pause();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] noise_key();
        logic [7:0] k;
        do k = 8'($urandom_range(0, 255));
        while ((k >= KEY_ZERO && k <= KEY_NINE) || k == KEY_ERASE);
        return k;
    endfunction

    function automatic logic [47:0] rand_code();
        logic [47:0] c;
        logic [7:0]  d;
        int i;
        if ($urandom_range(0, 99) < 15) begin
            d = ($urandom_range(0, 1) == 0) ? KEY_ZERO : KEY_NINE;
            return {6{d}};
        end
        for (i = 0; i < 6; i++)
            c[47 - 8*i -: 8] = KEY_ZERO + 8'($urandom_range(0, 9));
        return c;
    endfunction

    function automatic logic [47:0] mutate_code(input logic [47:0] code);
        logic [47:0] res;
        logic [7:0]  d;
        int pos;
        res = code;
        pos = $urandom_range(0, 5);
        d   = code[47 - 8*pos -: 8];
        d   = KEY_ZERO + 8'((int'(d - KEY_ZERO) + $urandom_range(1, 9)) % 10);
        res[47 - 8*pos -: 8] = d;
        return res;
    endfunction

    // Erases leftover digits (usually), then six digits, with now and then a stray
    // key, a slip corrected by erase, or a change request that the sequence should ignore.
    task automatic type_code(input logic [47:0] code);
        int i;
        int j;
        if (digits_held != 3'd0 && $urandom_range(0, 99) < 85) begin
            for (j = int'(digits_held); j > 0; j--)
                send_item(OP_KEY, KEY_ERASE);
        end
        for (i = 0; i < 6; i++) begin
            if ($urandom_range(0, 99) < 6)
                send_item(OP_KEY, noise_key());
            if (lock_phase != PH_ENTRY && $urandom_range(0, 99) < 3)
                send_item(OP_CHANGE, 8'($urandom_range(0, 255)));
            if (digits_held < 3'd5 && $urandom_range(0, 99) < 6) begin
                send_item(OP_KEY, KEY_ZERO + 8'($urandom_range(0, 9)));
                send_item(OP_KEY, KEY_ERASE);
            end
            send_item(OP_KEY, code[47 - 8*i -: 8]);
        end
    endtask

    task automatic lock_session();
        int r;
        int n;
        int i;
        case (lock_phase)
            PH_ENTRY: begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    send_item(OP_CHANGE, 8'($urandom_range(0, 255)));
                end else if (r < 85) begin
                    type_code(rand_code());
                end else if (r < 93) begin
                    n = $urandom_range(1, 5);
                    for (i = 0; i < n; i++)
                        send_item(OP_KEY, KEY_ZERO + 8'($urandom_range(0, 9)));
                    send_item(OP_CHANGE, 8'($urandom_range(0, 255)));
                end else begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++)
                        send_item(OP_KEY, 8'($urandom_range(0, 255)));
                end
            end
            PH_OLD: begin
                if ($urandom_range(0, 99) < 70) type_code(stored_code);
                else type_code(mutate_code(stored_code));
            end
            PH_NEW: begin
                type_code(rand_code());
            end
            PH_CONFIRM: begin
                if ($urandom_range(0, 99) < 75) type_code(pending_code);
                else type_code(mutate_code(pending_code));
            end
        endcase
    endtask

    task automatic test_entry_keys();
        int i;
        send_item(OP_KEY, KEY_ERASE);
        send_item(OP_KEY, 8'h00);
        send_item(OP_KEY, 8'hFF);
        send_item(OP_KEY, 8'h2F);
        send_item(OP_KEY, 8'h3A);
        send_item(OP_KEY, KEY_ZERO);
        send_item(OP_KEY, KEY_NINE);
        send_item(OP_KEY, KEY_ERASE);
        for (i = 0; i < 5; i++)
            send_item(OP_KEY, KEY_NINE - 8'(i));
    endtask

    task automatic test_change_requests();
        int i;
        send_item(OP_KEY, KEY_ZERO);
        send_item(OP_KEY, KEY_NINE);
        send_item(OP_CHANGE, 8'hFF);
        send_item(OP_CHANGE, 8'h00);
        for (i = 0; i < 6; i++)
            send_item(OP_KEY, KEY_ONE);
        send_item(OP_CHANGE, KEY_ZERO);
    endtask

    // Receiver stops for a long stretch while keys keep coming.
    task automatic test_receiver_hold();
        sender_pause();
        no_gaps = 1'b1;
        rx_hold_cycles = 80;
        wait (rx_holding);
        @(posedge aclk);
        repeat (2) type_code(rand_code());
        no_gaps = 1'b0;
    endtask

    task automatic test_full_rate();
        int start;
        start = effective_items;
        no_gaps = 1'b1;
        while (effective_items < start + 150)
            lock_session();
        no_gaps = 1'b0;
    endtask

    task automatic test_random_sessions();
        while (items_sent < RANDOM_TARGET) begin
            no_gaps = ($urandom_range(0, 99) < 5);
            lock_session();
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op    = OP_KEY;
        s_key   = 8'h00;
        stored_code  = {6{KEY_ONE}};
        entry_digits = '0;
        pending_code = '0;
        digits_held  = '0;
        lock_phase   = PH_ENTRY;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_entry_keys();
        test_change_requests();
        test_receiver_hold();
        test_full_rate();
        test_random_sessions();
        test_receiver_hold();

        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d items sent (%0d with effect), %0d results checked, %0d long stalls",
                 items_sent, effective_items, results_seen, holds_done);
        $display("events: entry %0d, old bad %0d, old ok %0d, new %0d, mismatch %0d, changed %0d",
                 event_tally[EV_ENTRY], event_tally[EV_OLD_BAD], event_tally[EV_OLD_OK],
                 event_tally[EV_NEW], event_tally[EV_MISMATCH], event_tally[EV_CHANGED]);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        int dur;
        logic v;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                v = 1'b0;
                dur = rx_hold_cycles;
                rx_holding = 1'b1;
            end else if (no_gaps) begin
                v = 1'b1;
                dur = 1;
            end else if ($urandom_range(0, 99) < 65) begin
                v = 1'b1;
                dur = $urandom_range(1, 8);
            end else begin
                v = 1'b0;
                dur = pick_gap() + 1;
            end
            m_ready <= v;
            repeat (dur) @(posedge aclk);
            if (rx_holding) begin
                rx_holding = 1'b0;
                rx_hold_cycles = 0;
                holds_done++;
            end
        end
    end

    always @(posedge aclk) begin
        kpl_result_t exp;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            event_tally[m_event_res]++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: ph=%0d cur=%0d ev=%0d code=%h",
                             m_phase, m_cursor, m_event_res, m_entry_code);
            end else begin
                exp = expected_results.pop_front();
                if (m_phase !== exp.phase || m_cursor !== exp.cursor
                    || m_echo_valid !== exp.echo_valid || m_echo_column !== exp.echo_column
                    || m_echo_char !== exp.echo_char || m_event_res !== exp.event_res
                    || m_entry_code !== exp.entry_code) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at result %0d", results_seen);
                        $display("  exp ph=%0d cur=%0d echo=%0d col=%0d chr=%h ev=%0d code=%h",
                                 exp.phase, exp.cursor, exp.echo_valid, exp.echo_column,
                                 exp.echo_char, exp.event_res, exp.entry_code);
                        $display("  got ph=%0d cur=%0d echo=%0d col=%0d chr=%h ev=%0d code=%h",
                                 m_phase, m_cursor, m_echo_valid, m_echo_column,
                                 m_echo_char, m_event_res, m_entry_code);
                    end
                end
            end
        end
    end

    initial begin
        wait (aresetn);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/kpl_pkg.sv
design/kpl_step.sv
design/keypad_password_lock_sequencer_top.sv
tb/sv/tb.sv
